@@ hdl/tmsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time message stability monitor package
// Shared item types, register codes and reset constants.
// ----------------------------------------------------------------------------
package tmsm_pkg;

    // Item kinds. The fourth code carries no meaning and changes no state.
    typedef enum logic [1:0] {
        KIND_MSG  = 2'd0,
        KIND_POLL = 2'd1,
        KIND_INIT = 2'd2
    } tmsm_kind_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRY_MS         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDED_WHEN_SET   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDED_WHEN_UNSET = 2'd2;

    // Register reset values.
    localparam logic [31:0] EXPIRY_MS_RST         = 32'd10000;
    localparam logic [15:0] NEEDED_WHEN_SET_RST   = 16'd1200;
    localparam logic [15:0] NEEDED_WHEN_UNSET_RST = 16'd60;

    // Timeout base at reset sits one full timeout behind zero, so the
    // timeout has already run out.
    localparam logic [31:0] TIMEOUT_BASE_RST = 32'd4294957296;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] msg_seconds;
        logic [31:0]        now_ms;
        logic               clock_set;
    } tmsm_in_t;

    typedef struct packed {
        logic               stable;
        logic               stopped;
        logic               jumped;
        logic signed [63:0] last_sec_out;
        logic [31:0]        last_ms_out;
    } tmsm_out_t;

    typedef struct packed {
        logic [31:0] expiry_ms;
        logic [15:0] needed_when_set;
        logic [15:0] needed_when_unset;
    } tmsm_cfg_t;

endpackage

@@ hdl/time_message_stability_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time message stability monitor
// Judges whether a stream of once-per-second time messages is stable.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while in_stall is low and returns
// exactly one result beat for each input beat, in order. An accepted beat
// lands in an input register; the core works out the new tracking state and
// the result from it, which is captured in the result register when the beat
// advances, raising out_valid. The throughput of one beat per cycle while
// nothing stalls is set by this two-register path: the single 64-bit sequence
// compare, the 32-bit elapsed-time subtract and the 16-bit count update all
// fit between the input and result registers. While the result register holds
// a beat that is stalled, the input register may still take one more beat;
// only when both are full and the result is stalled does in_stall rise.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle; writes to indexes beyond the three
// registers are accepted and ignored.
// ----------------------------------------------------------------------------
module time_message_stability_monitor
    import tmsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  tmsm_in_t               in_data,

    output logic                   out_valid,
    input  logic                   out_stall,
    output tmsm_out_t              out_data,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    tmsm_cfg_t  cfg_reg;
    logic       in_valid_reg;
    tmsm_in_t   in_reg;
    logic       out_valid_reg;
    tmsm_out_t  out_reg;
    tmsm_out_t  core_result;

    logic       out_free;
    logic       advance;
    logic       in_take;

    // The result register can take a new beat when it is empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    // The input register is free when empty or when its beat moves on now.
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.expiry_ms         <= EXPIRY_MS_RST;
            cfg_reg.needed_when_set   <= NEEDED_WHEN_SET_RST;
            cfg_reg.needed_when_unset <= NEEDED_WHEN_UNSET_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_EXPIRY_MS:         cfg_reg.expiry_ms         <= cfg_data;
                CFG_NEEDED_WHEN_SET:   cfg_reg.needed_when_set   <= cfg_data[15:0];
                CFG_NEEDED_WHEN_UNSET: cfg_reg.needed_when_unset <= cfg_data[15:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Input register: control bit is reset, payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_reg <= in_data;
        end
    end

    // The core steps its state exactly when a beat moves into the result register.
    tmsm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    // A beat waiting in the input register is never dropped while stalled.
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_reg))
        else $error("pending input beat lost");

    // Every beat that leaves the input register shows up as a result next cycle.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat produced no result");

    // The input side is only stalled when both registers are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with room to spare");

endmodule

@@ hdl/tmsm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time message stability monitor core
// Holds the tracking state and computes each item's result combinationally.
// ----------------------------------------------------------------------------
module tmsm_core
    import tmsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  tmsm_in_t  item,
    input  tmsm_cfg_t cfg,
    output tmsm_out_t result
);

    logic signed [63:0] last_sec_reg, last_sec_next;
    logic [31:0]        last_ms_reg, last_ms_next;
    logic               have_last_reg, have_last_next;
    logic [15:0]        count_reg, count_next;
    logic [31:0]        base_reg, base_next;
    logic               stopped_reg, stopped_next;

    logic               jumped;
    logic [15:0]        need;
    logic [31:0]        elapsed;
    logic               seq_ok;

    assign need    = item.clock_set ? cfg.needed_when_set : cfg.needed_when_unset;
    assign elapsed = item.now_ms - base_reg;
    assign seq_ok  = (item.msg_seconds == (last_sec_reg + 64'sd1));

    always_comb
    begin
        last_sec_next  = last_sec_reg;
        last_ms_next   = last_ms_reg;
        have_last_next = have_last_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        stopped_next   = stopped_reg;
        jumped         = 1'b0;
        case (item.kind)
            KIND_MSG:
            begin
                stopped_next   = 1'b0;
                base_next      = item.now_ms;
                last_sec_next  = item.msg_seconds;
                last_ms_next   = item.now_ms;
                have_last_next = 1'b1;
                if (have_last_reg) begin
                    if (!seq_ok) begin
                        jumped     = 1'b1;
                        count_next = '0;
                    end else if ((count_reg != need) && (count_reg != COUNT_MAX)) begin
                        count_next = count_reg + 16'd1;
                    end
                end
            end
            KIND_POLL:
            begin
                if (elapsed >= cfg.expiry_ms) begin
                    stopped_next = 1'b1;
                    count_next   = '0;
                end
            end
            KIND_INIT:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        result.stable       = (count_next == need);
        result.stopped      = stopped_next;
        result.jumped       = jumped;
        result.last_sec_out = last_sec_next;
        result.last_ms_out  = last_ms_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_sec_reg  <= '0;
            last_ms_reg   <= '0;
            have_last_reg <= 1'b0;
            count_reg     <= '0;
            base_reg      <= TIMEOUT_BASE_RST;
            stopped_reg   <= 1'b1;
        end else if (step_en) begin
            last_sec_reg  <= last_sec_next;
            last_ms_reg   <= last_ms_next;
            have_last_reg <= have_last_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            stopped_reg   <= stopped_next;
        end
    end

    // A message always clears the stopped flag and restarts the timeout.
    a_msg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.kind == KIND_MSG)
        |=> !stopped_reg && (base_reg == $past(item.now_ms)))
        else $error("message did not restart the timeout");

    // A jump drops confidence to zero.
    a_jump_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && jumped |=> (count_reg == 16'd0))
        else $error("confidence survived a jump");

    // An in-sequence message never lowers confidence.
    a_seq_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.kind == KIND_MSG) && !jumped
        |=> (count_reg >= $past(count_reg)))
        else $error("confidence dropped on an in-sequence message");

    // Stopped can only rise on a poll.
    a_stop_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stopped_reg) |-> $past(step_en) && ($past(item.kind) == KIND_POLL))
        else $error("stopped flag rose without a poll");

endmodule
